// ----- rtl/usbf_pkg.sv -----
// ----------------------------------------------------------------------------
// usbf_pkg
// Shared constants and types of the UDP source blocklist filter.
// ----------------------------------------------------------------------------
`default_nettype none

package usbf_pkg;

	localparam int TABLE_ENTRIES = 1024;

	localparam logic [15:0] OFF_ETH_HI   = 16'd12;
	localparam logic [15:0] OFF_ETH_LO   = 16'd13;
	localparam logic [15:0] OFF_PROTO    = 16'd23;
	localparam logic [15:0] OFF_SRC_LO   = 16'd26;
	localparam logic [15:0] OFF_SRC_HI   = 16'd29;
	localparam logic [15:0] OFF_UDP_LAST = 16'd33;
	localparam logic [15:0] OFF_PAYLOAD  = 16'd42;
	localparam logic [15:0] OFF_PAY_LAST = 16'd41;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

	localparam logic [2:0] REASON_SHORT   = 3'd0;
	localparam logic [2:0] REASON_NON_UDP = 3'd1;
	localparam logic [2:0] REASON_BLOCKED = 3'd2;
	localparam logic [2:0] REASON_SHORT_UDP = 3'd3;
	localparam logic [2:0] REASON_UNIFORM = 3'd4;
	localparam logic [2:0] REASON_PASS    = 3'd5;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_PROTOCOL  = 2'd1;
	localparam logic [1:0] REG_WINDOW    = 2'd2;

	localparam logic [7:0] THRESHOLD_RST = 8'd5;
	localparam logic [7:0] PROTOCOL_RST  = 8'd17;
	localparam logic [3:0] WINDOW_RST    = 4'd8;

	typedef struct packed {
		logic        active;
		logic [31:0] key;
		logic        bump;
		logic        found;
		logic        blocked;
		logic        placed;
		logic [7:0]  cnt;
	} token_t;

	typedef struct packed {
		logic        ipv4;
		logic        long_frame;
		logic        uniform;
		logic [7:0]  proto;
		logic [31:0] src;
	} frame_info_t;

endpackage

`default_nettype wire

// ----- rtl/usbf_in_if.sv -----
// ----------------------------------------------------------------------------
// usbf_in_if
// Frame byte channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface usbf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/usbf_out_if.sv -----
// ----------------------------------------------------------------------------
// usbf_out_if
// Verdict channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface usbf_out_if;
	logic        valid;
	logic        ready;
	logic        drop;
	logic [2:0]  reason;
	logic [31:0] source_address;
	logic [7:0]  entry_count;
	logic [63:0] pass_total;
	logic [63:0] blocked_total;

	modport source (output valid, output drop, output reason, output source_address,
		output entry_count, output pass_total, output blocked_total, input ready);
	modport sink (input valid, input drop, input reason, input source_address,
		input entry_count, input pass_total, input blocked_total, output ready);
endinterface

`default_nettype wire

// ----- rtl/usbf_parser.sv -----
// ----------------------------------------------------------------------------
// usbf_parser
// Tracks byte offset and captures header fields and payload uniformity.
// ----------------------------------------------------------------------------
`default_nettype none

module usbf_parser (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  beat,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  last_byte,
	input  wire logic [3:0]            window,
	output usbf_pkg::frame_info_t      info
);

	logic [15:0] off_q;
	logic [15:0] eth_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [7:0]  first_q;
	logic        mis_q;

	logic [15:0] eth_n;
	logic [7:0]  proto_n;
	logic [31:0] src_n;
	logic [7:0]  first_n;
	logic        mis_n;
	logic [3:0]  win_c;

	always_comb begin
		if (window == 4'd0) begin
			win_c = 4'd1;
		end else if (window > 4'd8) begin
			win_c = 4'd8;
		end else begin
			win_c = window;
		end
		eth_n = eth_q;
		if (off_q == usbf_pkg::OFF_ETH_HI) begin
			eth_n = {data_byte, 8'h00};
		end else if (off_q == usbf_pkg::OFF_ETH_LO) begin
			eth_n = eth_q | {8'h00, data_byte};
		end
		proto_n = (off_q == usbf_pkg::OFF_PROTO) ? data_byte : proto_q;
		src_n = (off_q >= usbf_pkg::OFF_SRC_LO && off_q <= usbf_pkg::OFF_SRC_HI) ?
			{src_q[23:0], data_byte} : src_q;
		first_n = (off_q == usbf_pkg::OFF_PAYLOAD) ? data_byte : first_q;
		mis_n = mis_q;
		if (off_q > usbf_pkg::OFF_PAYLOAD &&
			off_q < (usbf_pkg::OFF_PAYLOAD + {12'd0, win_c}) && data_byte != first_q) begin
			mis_n = 1'b1;
		end
		info.ipv4       = (off_q >= usbf_pkg::OFF_UDP_LAST) && (eth_n == usbf_pkg::ETHERTYPE_IPV4);
		info.long_frame = off_q >= usbf_pkg::OFF_PAY_LAST;
		info.uniform    = !mis_n;
		info.proto      = proto_n;
		info.src        = src_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			eth_q   <= '0;
			proto_q <= '0;
			src_q   <= '0;
			first_q <= '0;
			mis_q   <= 1'b0;
		end else if (beat) begin
			if (last_byte) begin
				off_q   <= '0;
				eth_q   <= '0;
				proto_q <= '0;
				src_q   <= '0;
				first_q <= '0;
				mis_q   <= 1'b0;
			end else begin
				if (off_q != 16'hFFFF) begin
					off_q <= off_q + 16'd1;
				end
				eth_q   <= eth_n;
				proto_q <= proto_n;
				src_q   <= src_n;
				first_q <= first_n;
				mis_q   <= mis_n;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/usbf_cell.sv -----
// ----------------------------------------------------------------------------
// usbf_cell
// One source table entry; matches, counts or claims the passing query token.
// ----------------------------------------------------------------------------
`default_nettype none

module usbf_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        threshold,
	input  wire usbf_pkg::token_t  tok_in,
	output usbf_pkg::token_t       tok_out
);

	logic        valid_q;
	logic [31:0] key_q;
	logic [7:0]  cnt_q;
	usbf_pkg::token_t tok_q;

	logic hit;
	logic claim;
	logic blk;
	logic [7:0] cnt_n;
	usbf_pkg::token_t tok_n;

	always_comb begin
		hit   = tok_in.active && valid_q && (key_q == tok_in.key);
		claim = tok_in.active && !valid_q && !tok_in.found && !tok_in.placed && tok_in.bump;
		blk   = cnt_q >= threshold;
		cnt_n = cnt_q;
		if (tok_in.bump && !blk && cnt_q != 8'hFF) begin
			cnt_n = cnt_q + 8'd1;
		end
		tok_n = tok_in;
		if (hit) begin
			tok_n.found   = 1'b1;
			tok_n.blocked = blk;
			tok_n.cnt     = cnt_n;
		end else if (claim) begin
			tok_n.placed = 1'b1;
			tok_n.cnt    = 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_n;
			if (claim) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			cnt_q <= cnt_n;
		end else if (claim) begin
			key_q <= tok_in.key;
			cnt_q <= 8'd1;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// ----- rtl/udp_source_blocklist_filter.sv -----
// ----------------------------------------------------------------------------
// udp_source_blocklist_filter
// Per-frame verdicts with a per-source uniform-payload blocklist.
//
//   channel     dir  handshake      payload
//   frame_in    in   valid/ready    data_byte, last_byte
//   verdict_out out  valid/ready    drop, reason, source_address, entry_count,
//                                   pass_total, blocked_total
//   apb         in   psel/penable   block_threshold, udp_protocol_number,
//                                   payload_window
//
// One byte per cycle inside a frame while input is not held. A last byte of an
// IPv4 frame of 34 bytes or more sends a query token down the 1024-cell table
// chain, one cell a cycle, so its verdict is registered once the token leaves
// the last cell; input holds during the walk. Other frames get their verdict the
// cycle after the last byte. Reset clears all table valid marks at once; no
// clearing pass. A stalled verdict holds input at every byte until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_source_blocklist_filter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	usbf_in_if.sink          frame_in,
	usbf_out_if.source       verdict_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [7:0] thr_q;
	logic [7:0] proto_cfg_q;
	logic [3:0] win_q;

	logic busy_q;
	logic proto_ok_q;
	logic long_q;
	logic uniform_q;
	logic [31:0] src_q;

	logic        out_valid_q;
	logic        drop_q;
	logic [2:0]  reason_q;
	logic [31:0] addr_q;
	logic [7:0]  count_q;
	logic [63:0] pass_q;
	logic [63:0] blk_q;

	logic accept;
	logic launch;
	logic direct;
	logic done;
	logic proto_eq;
	logic [2:0] reason_n;
	usbf_pkg::frame_info_t info;
	usbf_pkg::token_t tok [0:usbf_pkg::TABLE_ENTRIES];

	assign pready = 1'b1;

	always_comb begin
		case (paddr[3:2])
			usbf_pkg::REG_THRESHOLD: prdata = {24'd0, thr_q};
			usbf_pkg::REG_PROTOCOL:  prdata = {24'd0, proto_cfg_q};
			usbf_pkg::REG_WINDOW:    prdata = {28'd0, win_q};
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= usbf_pkg::THRESHOLD_RST;
			proto_cfg_q <= usbf_pkg::PROTOCOL_RST;
			win_q       <= usbf_pkg::WINDOW_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				usbf_pkg::REG_THRESHOLD: thr_q       <= pwdata[7:0];
				usbf_pkg::REG_PROTOCOL:  proto_cfg_q <= pwdata[7:0];
				usbf_pkg::REG_WINDOW:    win_q       <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	assign frame_in.ready = !busy_q && (!out_valid_q || verdict_out.ready);
	assign accept = frame_in.valid && frame_in.ready;

	usbf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (accept),
		.data_byte (frame_in.data_byte),
		.last_byte (frame_in.last_byte),
		.window    (win_q),
		.info      (info)
	);

	assign proto_eq = info.proto == proto_cfg_q;
	assign launch   = accept && frame_in.last_byte && info.ipv4;
	assign direct   = accept && frame_in.last_byte && !info.ipv4;

	always_comb begin
		tok[0]         = '0;
		tok[0].active  = launch;
		tok[0].key     = info.src;
		tok[0].bump    = proto_eq && info.long_frame && info.uniform;
	end

	for (genvar i = 0; i < usbf_pkg::TABLE_ENTRIES; i++) begin : g_cell
		usbf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.threshold (thr_q),
			.tok_in    (tok[i]),
			.tok_out   (tok[i+1])
		);
	end

	assign done = tok[usbf_pkg::TABLE_ENTRIES].active;

	always_comb begin
		if (!proto_ok_q) begin
			reason_n = usbf_pkg::REASON_NON_UDP;
		end else if (tok[usbf_pkg::TABLE_ENTRIES].blocked) begin
			reason_n = usbf_pkg::REASON_BLOCKED;
		end else if (!long_q) begin
			reason_n = usbf_pkg::REASON_SHORT_UDP;
		end else if (uniform_q) begin
			reason_n = usbf_pkg::REASON_UNIFORM;
		end else begin
			reason_n = usbf_pkg::REASON_PASS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			pass_q      <= '0;
			blk_q       <= '0;
		end else begin
			if (launch) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (direct || done) begin
				out_valid_q <= 1'b1;
			end else if (verdict_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (done && reason_n == usbf_pkg::REASON_PASS) begin
				pass_q <= pass_q + 64'd1;
			end
			if (done && reason_n == usbf_pkg::REASON_BLOCKED) begin
				blk_q <= blk_q + 64'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			proto_ok_q <= proto_eq;
			long_q     <= info.long_frame;
			uniform_q  <= info.uniform;
			src_q      <= info.src;
		end
		if (direct) begin
			drop_q   <= 1'b0;
			reason_q <= usbf_pkg::REASON_SHORT;
			addr_q   <= '0;
			count_q  <= '0;
		end else if (done) begin
			drop_q   <= (reason_n == usbf_pkg::REASON_BLOCKED) ||
				(reason_n == usbf_pkg::REASON_UNIFORM);
			reason_q <= reason_n;
			addr_q   <= src_q;
			count_q  <= tok[usbf_pkg::TABLE_ENTRIES].cnt;
		end
	end

	assign verdict_out.valid          = out_valid_q;
	assign verdict_out.drop           = drop_q;
	assign verdict_out.reason         = reason_q;
	assign verdict_out.source_address = addr_q;
	assign verdict_out.entry_count    = count_q;
	assign verdict_out.pass_total     = pass_q;
	assign verdict_out.blocked_total  = blk_q;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy_q) else $error("token left chain with no lookup pending");
	a_done_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !out_valid_q) else $error("verdict slot occupied at lookup end");
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !frame_in.ready) else $error("word taken during table walk");
	a_launch_clr: assert property (@(posedge clk) disable iff (!arst_n)
		launch |=> busy_q && !out_valid_q) else $error("lookup launch state wrong");

endmodule

`default_nettype wire
